### hdl/rxb_pkg.sv
// shared types, codes and helpers of the reservoir exchange bound block
`timescale 1ns / 1ps

package rxb_pkg;

	localparam int HOURS  = 256;
	localparam int HOUR_W = 8;
	localparam int IN_W   = 248;
	localparam int OUT_W  = 72;
	localparam int ADDR_W = 4;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ABOVE_MAX = 3'd1,
		ST_BELOW_MIN = 3'd2,
		ST_LEVEL     = 3'd3,
		ST_INIT_CAP  = 3'd4,
		ST_BAD_HOUR  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_INIT = 2'd0,
		REG_CAP  = 2'd1,
		REG_EFF  = 2'd2,
		REG_MODE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] unsup;
		logic signed [31:0] pmax;
		logic signed [31:0] pmin;
		logic signed [31:0] gen;
	} hour_rec_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sh007FFFFFFF) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -40'sh0080000000) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### hdl/reservoir_exchange_bound_top.sv
// reservoir exchange bound: hour tables, level tracking and span scan over block memories
// load: a good hour passes through L1 and L2 to OUT, a bad hour goes straight to OUT; the next beat waits for idle
// query: states QX, QN, SCAN, TERM and QRES lead to OUT, where the result is registered; the
//   span is read one stored level per cycle in SCAN, and the next beat is taken only in idle
// stalls: a result still waiting at the output holds the next result and the input behind it
// reset: config registers, state and output valid reset, running level and next hour cleared; datapath and memories not
`timescale 1ns / 1ps

module reservoir_exchange_bound_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// op
	input  logic                         s_tuser,
	// hour, generation, min_power, max_power, unsupplied_energy, inflow, spill,
	// pump_energy, max_gen_hour, min_gen_hour
	input  logic [rxb_pkg::IN_W-1:0]     s_tdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// exchange_bound, level_out, status, zero fill
	output logic [rxb_pkg::OUT_W-1:0]    m_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rxb_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import rxb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_L1, S_L2, S_QX, S_QN, S_SCAN, S_TERM, S_QRES, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic signed [31:0] init_q;
	logic [30:0]        cap_q;
	logic [17:0]        eff_q;
	logic               mode_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			cap_q  <= '0;
			eff_q  <= 18'd65536;
			mode_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_INIT: init_q <= pwdata;
				REG_CAP:  cap_q  <= pwdata[30:0];
				REG_EFF:  eff_q  <= pwdata[17:0];
				REG_MODE: mode_q <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_INIT: prdata = init_q;
			REG_CAP:  prdata = {1'b0, cap_q};
			REG_EFF:  prdata = {14'd0, eff_q};
			REG_MODE: prdata = {31'd0, mode_q};
		endcase
	end

	// input fields
	logic [HOUR_W-1:0]  in_hour, in_max_h, in_min_h;
	logic signed [31:0] in_gen, in_pmin, in_pmax, in_unsup, in_inflow, in_spill, in_pump;

	assign in_hour   = s_tdata[7:0];
	assign in_gen    = s_tdata[39:8];
	assign in_pmin   = s_tdata[71:40];
	assign in_pmax   = s_tdata[103:72];
	assign in_unsup  = s_tdata[135:104];
	assign in_inflow = s_tdata[167:136];
	assign in_spill  = s_tdata[199:168];
	assign in_pump   = s_tdata[231:200];
	assign in_max_h  = s_tdata[239:232];
	assign in_min_h  = s_tdata[247:240];

	logic accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// control state
	logic [HOUR_W:0]    next_q;
	logic signed [31:0] run_q;
	logic               hour_ok;
	logic signed [31:0] prev;

	assign hour_ok = (in_hour == '0) || ({1'b0, in_hour} == next_q);
	assign prev    = (in_hour == '0) ? init_q : run_q;

	// datapath registers
	logic [HOUR_W-1:0]  hour_q, hn_q;
	logic [HOUR_W:0]    hi_q, ptr_q, lidx_s1;
	logic               dirmin_q, equal_q;
	logic signed [31:0] ext_q;
	logic signed [50:0] prod_s1;
	logic signed [32:0] s1_q, s2_q;
	status_t            pst_q;
	logic signed [31:0] lvl_q;
	logic signed [32:0] at_max_q, at_min_q, base_q;
	logic signed [33:0] term_q;
	logic signed [31:0] res_bound_q, res_level_q;
	status_t            res_st_q;
	logic               out_load;

	// memories
	hour_rec_t          dmem [HOURS];
	logic signed [31:0] lmem [HOURS];
	hour_rec_t          drd_s1;
	logic signed [31:0] lrd_s1;
	logic [HOUR_W-1:0]  daddr;
	logic               dwe, lwe;

	assign daddr = (state_q == S_IDLE) ? in_max_h : hn_q;
	assign dwe   = accept && (s_tuser == OP_LOAD) && hour_ok;
	assign lwe   = (state_q == S_L2) && mode_q;

	always_ff @(posedge clk) begin
		if (dwe) begin
			dmem[in_hour] <= '{unsup: in_unsup, pmax: in_pmax, pmin: in_pmin, gen: in_gen};
		end
		drd_s1 <= dmem[daddr];
	end

	always_ff @(posedge clk) begin
		if (lwe) begin
			lmem[hour_q] <= lvl_q;
		end
		lrd_s1  <= lmem[ptr_q[HOUR_W-1:0]];
		lidx_s1 <= ptr_q;
	end

	// load arithmetic
	logic signed [32:0] g33;
	logic               above, below;
	logic signed [50:0] prod_rnd;
	logic signed [34:0] pumped;
	logic signed [39:0] lvl_sum;
	logic signed [31:0] lvl_next;

	assign g33      = {in_gen[31], in_gen};
	assign above    = g33 > ($signed({in_pmax[31], in_pmax}) + 33'sd1);
	assign below    = g33 < ($signed({in_pmin[31], in_pmin}) - 33'sd1);
	assign prod_rnd = prod_s1 + 51'sd32768;
	assign pumped   = prod_rnd[50:16];
	assign lvl_sum  = {{7{s1_q[32]}}, s1_q} + {{7{s2_q[32]}}, s2_q}
		+ {{5{pumped[34]}}, pumped};
	assign lvl_next = sat32(lvl_sum);

	// load status
	logic signed [32:0] cap33, init33, lvl33;
	status_t            load_st;

	assign cap33  = {2'b00, cap_q};
	assign init33 = {init_q[31], init_q};
	assign lvl33  = {lvl_q[31], lvl_q};

	always_comb begin
		priority if (pst_q != ST_OK) begin
			load_st = pst_q;
		end else if (mode_q && (init33 > cap33)) begin
			load_st = ST_INIT_CAP;
		end else if (mode_q && ((lvl33 > cap33 + 33'sd1) || (lvl33 < -33'sd1))) begin
			load_st = ST_LEVEL;
		end else begin
			load_st = ST_OK;
		end
	end

	// query arithmetic
	logic signed [32:0] d_gen, d_pmin, d_pmax, d_unsup;
	logic signed [32:0] head, at_min_next, base_next;
	logic               in_span, last_beat;
	logic signed [33:0] cap34, ext34, term_next, fin_min;

	assign d_gen       = {drd_s1.gen[31], drd_s1.gen};
	assign d_pmin      = {drd_s1.pmin[31], drd_s1.pmin};
	assign d_pmax      = {drd_s1.pmax[31], drd_s1.pmax};
	assign d_unsup     = {drd_s1.unsup[31], drd_s1.unsup};
	assign head        = d_pmax - d_gen;
	assign at_min_next = (d_unsup < head) ? d_unsup : head;
	assign base_next   = (at_max_q < at_min_q) ? at_max_q : at_min_q;
	assign in_span     = lidx_s1 < hi_q;
	assign last_beat   = ({1'b0, lidx_s1} + 10'd1) >= {1'b0, hi_q};
	assign cap34       = {3'b000, cap_q};
	assign ext34       = {{2{ext_q[31]}}, ext_q};

	always_comb begin
		logic signed [33:0] t;
		t = dirmin_q ? ext34 : (cap34 - ext34);
		priority if (!mode_q) begin
			term_next = 34'sh1FFFFFFFF;
		end else if (equal_q) begin
			term_next = cap34;
		end else begin
			term_next = (t < cap34) ? t : cap34;
		end
	end

	assign fin_min  = ($signed({base_q[32], base_q}) < term_q) ? {base_q[32], base_q} : term_q;
	assign out_load = (state_q == S_OUT) && (!m_tvalid || m_tready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			next_q   <= '0;
			run_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (s_tuser == OP_QUERY) begin
							state_q <= S_QX;
						end else if (hour_ok) begin
							next_q  <= {1'b0, in_hour} + 9'd1;
							state_q <= S_L1;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_L1: begin
					if (mode_q) begin
						run_q <= lvl_next;
					end
					state_q <= S_L2;
				end
				S_L2:   state_q <= S_OUT;
				S_QX:   state_q <= S_QN;
				S_QN:   state_q <= S_SCAN;
				S_SCAN: begin
					if (last_beat) begin
						state_q <= S_TERM;
					end
				end
				S_TERM: state_q <= S_QRES;
				S_QRES: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					hour_q   <= in_hour;
					hn_q     <= in_min_h;
					dirmin_q <= in_min_h < in_max_h;
					equal_q  <= in_min_h == in_max_h;
					ptr_q    <= {1'b0, (in_min_h < in_max_h) ? in_min_h : in_max_h};
					hi_q     <= {1'b0, (in_min_h < in_max_h) ? in_max_h : in_min_h};
					ext_q    <= (in_min_h < in_max_h) ? 32'sh7FFFFFFF : 32'sh80000000;
					prod_s1  <= $signed({1'b0, eff_q}) * in_pump;
					s1_q     <= {in_inflow[31], in_inflow} - {in_spill[31], in_spill};
					s2_q     <= {prev[31], prev} - g33;
					pst_q    <= above ? ST_ABOVE_MAX : (below ? ST_BELOW_MIN : ST_OK);
					res_bound_q <= '0;
					res_level_q <= mode_q ? run_q : '0;
					res_st_q    <= ST_BAD_HOUR;
				end
			end
			S_L1: lvl_q <= lvl_next;
			S_L2: begin
				res_bound_q <= '0;
				res_level_q <= mode_q ? lvl_q : '0;
				res_st_q    <= load_st;
			end
			S_QX: begin
				at_max_q <= d_gen - d_pmin;
				ptr_q    <= ptr_q + 9'd1;
			end
			S_QN, S_SCAN: begin
				if (state_q == S_QN) begin
					at_min_q <= at_min_next;
				end else begin
					base_q <= base_next;
				end
				if (in_span) begin
					if (dirmin_q) begin
						ext_q <= (lrd_s1 < ext_q) ? lrd_s1 : ext_q;
					end else begin
						ext_q <= (lrd_s1 > ext_q) ? lrd_s1 : ext_q;
					end
				end
				ptr_q <= ptr_q + 9'd1;
			end
			S_TERM: term_q <= term_next;
			S_QRES: begin
				res_bound_q <= sat32({{6{fin_min[33]}}, fin_min});
				res_level_q <= '0;
				res_st_q    <= ST_OK;
			end
			S_OUT: begin
				if (out_load) begin
					m_tdata <= {5'd0, res_st_q, res_level_q, res_bound_q};
				end
			end
			default: ;
		endcase
	end

endmodule
